// ===== src/pcm_mix_pkg.sv =====
// ============================================================================
// PCM playback mixer package
// Shared types, codes and default sizes for the eight-voice PCM mixer.
// ============================================================================
package pcm_mix_pkg;

    // default sizes
    localparam int DEF_NUM_VOICES    = 8;
    localparam int DEF_FRACTION_BITS = 11;
    localparam int DEF_WAVE_BYTES    = 65536;

    localparam int VOICE_SLOTS = 8;
    localparam int VOICE_W     = 3;

    // operation codes
    localparam logic [1:0] OP_REG  = 2'd0;
    localparam logic [1:0] OP_MEM  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;
    localparam logic [1:0] OP_RSVD = 2'd3;

    // register indexes
    localparam logic [3:0] REG_ENV      = 4'd0;
    localparam logic [3:0] REG_PAN      = 4'd1;
    localparam logic [3:0] REG_STEP_LO  = 4'd2;
    localparam logic [3:0] REG_STEP_HI  = 4'd3;
    localparam logic [3:0] REG_LOOP_LO  = 4'd4;
    localparam logic [3:0] REG_LOOP_HI  = 4'd5;
    localparam logic [3:0] REG_START    = 4'd6;
    localparam logic [3:0] REG_CTRL     = 4'd7;
    localparam logic [3:0] REG_ONOFF    = 4'd8;
    localparam logic [3:0] REG_RSVD     = 4'hF;

    // configuration register indexes
    localparam logic [1:0] CFG_MASTER_VOLUME = 2'd0;
    localparam logic [1:0] CFG_MUTE_MASK     = 2'd1;

    localparam logic [7:0]  STOP_BYTE     = 8'hFF;
    localparam logic [14:0] MASTER_RESET  = 15'd8192;
    localparam logic [11:0] BANK_END      = 12'hFFF;
    localparam logic [19:0] MIX_MAX       = 20'sd32767;
    localparam logic [19:0] MIX_MIN       = -20'sd32768;
    localparam logic [19:0] CLAMP_MIN     = -20'sd32767;

    // controller states
    typedef enum logic [15:0] {
        S_CLEAR   = 16'h0001,
        S_IDLE    = 16'h0002,
        S_EXEC    = 16'h0004,
        S_VSEL    = 16'h0008,
        S_RD1     = 16'h0010,
        S_RD2     = 16'h0020,
        S_MUL1    = 16'h0040,
        S_MUL2    = 16'h0080,
        S_MUL3    = 16'h0100,
        S_MIX     = 16'h0200,
        S_SCAN_RD = 16'h0400,
        S_SCAN_CK = 16'h0800,
        S_FIN     = 16'h1000,
        S_NEXT    = 16'h2000,
        S_DONE    = 16'h4000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clr_step;
        logic latch;
        logic exec;
        logic vsel;
        logic rd1;
        logic rd2;
        logic mul1;
        logic mul2;
        logic mul3;
        logic mix;
        logic scan_rd;
        logic scan_ck;
        logic fin;
        logic next;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic       clear_last;
        logic [1:0] op;
        logic       voice_en;
        logic       rd_stop;
        logic       scan_more;
        logic       last_voice;
        logic       out_free;
    } t_status;

endpackage

// ===== src/pcm_mix_ctrl.sv =====
// ============================================================================
// PCM mixer controller
// Sequences item execution, the per-voice tick walk and the wave clear pass.
// ============================================================================
module pcm_mix_ctrl
    import pcm_mix_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_status i_st,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_st.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = (i_st.op == OP_TICK) ? S_VSEL : S_DONE;
            end
            S_VSEL: begin
                o_cmd.vsel = 1'b1;
                n_state    = i_st.voice_en ? S_RD1 : S_NEXT;
            end
            S_RD1: begin
                o_cmd.rd1 = 1'b1;
                n_state   = i_st.rd_stop ? S_RD2 : S_MUL1;
            end
            S_RD2: begin
                o_cmd.rd2 = 1'b1;
                n_state   = i_st.rd_stop ? S_FIN : S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_MUL3;
            end
            S_MUL3: begin
                o_cmd.mul3 = 1'b1;
                n_state    = S_MIX;
            end
            S_MIX: begin
                o_cmd.mix = 1'b1;
                n_state   = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = i_st.scan_more ? S_SCAN_CK : S_FIN;
            end
            S_SCAN_CK: begin
                o_cmd.scan_ck = 1'b1;
                n_state       = i_st.rd_stop ? S_FIN : S_SCAN_RD;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_NEXT;
            end
            S_NEXT: begin
                o_cmd.next = 1'b1;
                n_state    = i_st.last_voice ? S_DONE : S_VSEL;
            end
            S_DONE: begin
                if (i_st.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// ===== src/pcm_mix_dp.sv =====
// ============================================================================
// PCM mixer datapath
// Voice registers, wave memory, scaling multipliers, mixer and output stage.
// ============================================================================
module pcm_mix_dp
    import pcm_mix_pkg::*;
#(
    parameter int NUM_VOICES    = DEF_NUM_VOICES,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS,
    parameter int WAVE_BYTES    = DEF_WAVE_BYTES
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_st,
    input  logic        i_cfg_valid,
    input  logic [1:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data,
    input  logic [1:0]  i_operation,
    input  logic [3:0]  i_register_index,
    input  logic [15:0] i_memory_address,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [15:0] o_left_sample,
    output logic signed [15:0] o_right_sample,
    output logic [7:0]  o_start_mask,
    output logic [7:0]  o_stop_mask,
    output logic [7:0]  o_irq_channel_mask,
    output logic [15:0] o_irq_bank_mask
);

    localparam int FB     = FRACTION_BITS;
    localparam int ADDR_W = 16 + FRACTION_BITS;
    localparam int AW     = $clog2(WAVE_BYTES);
    localparam logic [7:0] VMASK = 8'((1 << NUM_VOICES) - 1);
    localparam logic [VOICE_W-1:0] TOP_VOICE = VOICE_W'(NUM_VOICES - 1);

    // configuration
    logic [14:0] r_master;
    logic [7:0]  r_mute;

    // voice state
    logic [7:0]        r_env   [VOICE_SLOTS];
    logic [7:0]        r_pan   [VOICE_SLOTS];
    logic [7:0]        r_page  [VOICE_SLOTS];
    logic [15:0]       r_step  [VOICE_SLOTS];
    logic [15:0]       r_loop  [VOICE_SLOTS];
    logic [ADDR_W-1:0] r_play  [VOICE_SLOTS];
    logic [VOICE_W-1:0] r_sel;
    logic              r_playing;
    logic [7:0]        r_off;

    // latched item
    logic [1:0]  r_op;
    logic [3:0]  r_reg;
    logic [15:0] r_maddr;
    logic [7:0]  r_data;

    // working registers
    logic [VOICE_W-1:0] r_voice;
    logic [ADDR_W-1:0]  r_addr;
    logic [15:0]        r_ra;
    logic               r_at_stop;
    logic [7:0]         r_d;
    logic [11:0]        r_vol_l, r_vol_r;
    logic [14:0]        r_mag_l, r_mag_r;
    logic [16:0]        r_scl_l, r_scl_r;
    logic signed [19:0] r_lout, r_rout;
    logic [7:0]         r_irqc;
    logic [15:0]        r_irqb;
    logic [16:0]        r_scan, r_end;
    logic [7:0]         r_start, r_stop;
    logic [AW-1:0]      r_clr;
    logic               r_out_valid;

    // wave memory
    logic [7:0]  r_wave [WAVE_BYTES];
    logic [7:0]  r_rdata;
    logic [15:0] rd_addr;
    logic        mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]  mem_wdata;

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master <= MASTER_RESET;
            r_mute   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MASTER_VOLUME: r_master <= i_cfg_data;
                CFG_MUTE_MASK:     r_mute   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // memory ports
    always_comb begin
        rd_addr = r_scan[15:0];
        if (i_cmd.vsel) rd_addr = r_play[r_voice][FB+15:FB];
        else if (i_cmd.rd1) rd_addr = r_loop[r_voice];
        mem_we    = i_cmd.clr_step || (i_cmd.exec && r_op == OP_MEM);
        mem_waddr = i_cmd.clr_step ? r_clr : r_maddr[AW-1:0];
        mem_wdata = i_cmd.clr_step ? STOP_BYTE : r_data;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_wave[mem_waddr] <= mem_wdata;
        r_rdata <= r_wave[rd_addr[AW-1:0]];
    end

    // clear pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // register write decode
    logic [7:0] wr_start, wr_stop;
    always_comb begin
        wr_start = '0;
        wr_stop  = '0;
        if (r_reg == REG_CTRL) begin
            if (r_data[7]) begin
                if (!r_playing) wr_start = ~r_off;
            end else begin
                wr_stop = ~r_off;
            end
        end else if (r_reg == REG_ONOFF && r_playing) begin
            wr_start = r_off & ~r_data;
            wr_stop  = ~r_off & r_data;
        end
        wr_start = wr_start & VMASK;
        wr_stop  = wr_stop & VMASK;
    end

    // mixer arithmetic
    logic signed [19:0] val_l, val_r, mix_l, mix_r, sum_l, sum_r;
    always_comb begin
        val_l = r_d[7] ? -$signed({3'b0, r_scl_l}) : $signed({3'b0, r_scl_l});
        val_r = r_d[7] ? -$signed({3'b0, r_scl_r}) : $signed({3'b0, r_scl_r});
        sum_l = r_lout + val_l;
        sum_r = r_rout + val_r;
        mix_l = sum_l;
        mix_r = sum_r;
        // halve toward zero on overflow
        if (sum_l < $signed(MIX_MIN) || sum_l > $signed(MIX_MAX))
            mix_l = $signed(sum_l + {19'b0, sum_l[19]}) >>> 1;
        if (sum_r < $signed(MIX_MIN) || sum_r > $signed(MIX_MAX))
            mix_r = $signed(sum_r + {19'b0, sum_r[19]}) >>> 1;
    end

    // address advance
    logic [ADDR_W:0]   adv_sum;
    logic [3:0]        pb, nb;
    logic [ADDR_W-1:0] adv_addr;
    logic [ADDR_W:0]   end_sum;
    logic [ADDR_W:0]   end_byte;
    always_comb begin
        adv_sum  = {1'b0, r_addr} + (ADDR_W+1)'(r_step[r_voice]);
        pb       = r_addr[FB+15:FB+12];
        nb       = adv_sum[FB+15:FB+12];
        adv_addr = (pb != nb && nb == 4'd0) ? '0 : adv_sum[ADDR_W-1:0];
        end_sum  = {1'b0, adv_addr} + (ADDR_W+1)'(r_step[r_voice]);
        end_byte = end_sum >> FB;
    end

    // voice state and tick walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < VOICE_SLOTS; v++) begin
                r_env[v]  <= 8'hFF;
                r_pan[v]  <= '0;
                r_page[v] <= '0;
                r_step[v] <= '0;
                r_loop[v] <= '0;
                r_play[v] <= '0;
            end
            r_sel     <= '0;
            r_playing <= 1'b0;
            r_off     <= 8'hFF;
        end else begin
            if (i_cmd.exec && r_op == OP_REG) begin
                case (r_reg)
                    REG_ENV:     r_env[r_sel] <= r_data;
                    REG_PAN:     r_pan[r_sel] <= r_data;
                    REG_STEP_LO: r_step[r_sel][7:0] <= r_data;
                    REG_STEP_HI: r_step[r_sel][15:8] <= r_data;
                    REG_LOOP_LO: r_loop[r_sel][7:0] <= r_data;
                    REG_LOOP_HI: r_loop[r_sel][15:8] <= r_data;
                    REG_START: begin
                        r_page[r_sel] <= r_data;
                        r_play[r_sel] <= {r_data, 8'h00, FB'(0)};
                    end
                    REG_CTRL: begin
                        if (r_data[6]) r_sel <= r_data[VOICE_W-1:0];
                        r_playing <= r_data[7];
                    end
                    REG_ONOFF:   r_off <= r_data;
                    default: ;
                endcase
                for (int v = 0; v < VOICE_SLOTS; v++) begin
                    if (wr_start[v] || wr_stop[v]) r_play[v] <= {r_page[v], 8'h00, FB'(0)};
                end
            end
            // store the voice's final address
            if (i_cmd.fin) begin
                r_play[r_voice] <= r_at_stop ? {r_loop[r_voice], FB'(0)} : r_addr;
            end
        end
    end

    // working datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op    <= i_operation;
            r_reg   <= i_register_index;
            r_maddr <= i_memory_address;
            r_data  <= i_data_byte;
        end
        if (i_cmd.exec) begin
            r_voice <= TOP_VOICE;
            r_lout  <= '0;
            r_rout  <= '0;
            r_irqc  <= '0;
            r_irqb  <= '0;
            r_start <= (r_op == OP_REG) ? wr_start : 8'h00;
            r_stop  <= (r_op == OP_REG) ? wr_stop : 8'h00;
        end
        if (i_cmd.vsel) begin
            r_addr    <= r_play[r_voice];
            r_ra      <= r_play[r_voice][FB+15:FB];
            r_at_stop <= 1'b0;
        end
        // first byte: a stop byte jumps to loop start
        if (i_cmd.rd1) begin
            if (r_rdata == STOP_BYTE) begin
                if (r_ra[11:0] == BANK_END) begin
                    r_irqc[r_voice] <= 1'b1;
                    r_irqb[r_addr[FB+15:FB+12]] <= 1'b1;
                end
                r_addr <= {r_loop[r_voice], FB'(0)};
                r_ra   <= r_loop[r_voice];
            end else begin
                r_d <= r_rdata;
            end
        end
        if (i_cmd.rd2) begin
            if (r_rdata == STOP_BYTE) r_at_stop <= 1'b1;
            else r_d <= r_rdata;
        end
        // pan nibble times envelope
        if (i_cmd.mul1) begin
            r_vol_l <= r_pan[r_voice][3:0] * r_env[r_voice];
            r_vol_r <= r_pan[r_voice][7:4] * r_env[r_voice];
        end
        if (i_cmd.mul2) begin
            r_mag_l <= 15'((19'(r_d[6:0]) * 19'(r_vol_l)) >> 4);
            r_mag_r <= 15'((19'(r_d[6:0]) * 19'(r_vol_r)) >> 4);
        end
        // master volume, magnitude truncates toward zero
        if (i_cmd.mul3) begin
            r_scl_l <= 17'((30'(r_mag_l) * 30'(r_master)) >> 13);
            r_scl_r <= 17'((30'(r_mag_r) * 30'(r_master)) >> 13);
        end
        if (i_cmd.mix) begin
            if (!r_mute[r_voice]) begin
                r_lout <= mix_l;
                r_rout <= mix_r;
            end
            if (pb != nb) begin
                r_irqc[r_voice] <= 1'b1;
                r_irqb[pb]      <= 1'b1;
            end
            r_addr <= adv_addr;
            r_scan <= {1'b0, adv_addr[FB+15:FB]};
            r_end  <= (end_byte > (ADDR_W+1)'(17'h10000)) ? 17'h10000 : end_byte[16:0];
        end
        // look-ahead scan for a stop byte
        if (i_cmd.scan_ck) begin
            if (r_rdata == STOP_BYTE) begin
                r_ra      <= r_scan[15:0];
                r_at_stop <= 1'b1;
            end else begin
                r_scan <= r_scan + 1'b1;
            end
        end
        if (i_cmd.fin && r_at_stop && r_ra[11:0] == BANK_END) begin
            r_irqc[r_voice] <= 1'b1;
            r_irqb[r_addr[FB+15:FB+12]] <= 1'b1;
        end
        if (i_cmd.next) r_voice <= r_voice - 1'b1;
    end

    // output stage
    logic signed [19:0] clamp_l, clamp_r;
    always_comb begin
        clamp_l = r_lout;
        clamp_r = r_rout;
        if (r_lout < $signed(CLAMP_MIN)) clamp_l = CLAMP_MIN;
        if (r_lout > $signed(MIX_MAX))   clamp_l = MIX_MAX;
        if (r_rout < $signed(CLAMP_MIN)) clamp_r = CLAMP_MIN;
        if (r_rout > $signed(MIX_MAX))   clamp_r = MIX_MAX;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_left_sample      <= clamp_l[15:0];
            o_right_sample     <= clamp_r[15:0];
            o_start_mask       <= r_start;
            o_stop_mask        <= r_stop;
            o_irq_channel_mask <= r_irqc;
            o_irq_bank_mask    <= r_irqb;
        end
    end

    assign o_valid = r_out_valid;

    // status
    always_comb begin
        o_st.clear_last = &r_clr;
        o_st.op         = r_op;
        o_st.voice_en   = !r_off[r_voice] && (r_step[r_voice] != 16'd0);
        o_st.rd_stop    = (r_rdata == STOP_BYTE);
        o_st.scan_more  = (r_scan < r_end);
        o_st.last_voice = (r_voice == '0);
        o_st.out_free   = !r_out_valid || i_ready;
    end

endmodule

// ===== src/eight_channel_pcm_playback_mixer.sv =====
// ============================================================================
// Eight-channel PCM playback mixer
// Top level: controller and datapath of the sign-magnitude PCM mixer.
// ============================================================================
// After reset the block fills all WAVE_BYTES locations (65536 by default) of
// the wave memory with stop bytes and accepts no item until done; config
// writes are taken at any time. In a tick, each enabled voice's reads and
// look-ahead scan share the single read port of the wave memory, which
// serves them one byte at a time. WAVE_BYTES must be a power of two; the
// block itself does not enforce it.
module eight_channel_pcm_playback_mixer
    import pcm_mix_pkg::*;
#(
    parameter int NUM_VOICES    = DEF_NUM_VOICES,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS,
    parameter int WAVE_BYTES    = DEF_WAVE_BYTES
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [3:0]  i_register_index,
    input  logic [15:0] i_memory_address,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [15:0] o_left_sample,
    output logic signed [15:0] o_right_sample,
    output logic [7:0]  o_start_mask,
    output logic [7:0]  o_stop_mask,
    output logic [7:0]  o_irq_channel_mask,
    output logic [15:0] o_irq_bank_mask,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data
);

    t_cmd    cmd;
    t_status st;

    // config beats are always taken
    assign o_cfg_ready = 1'b1;

    pcm_mix_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    pcm_mix_dp #(
        .NUM_VOICES    (NUM_VOICES),
        .FRACTION_BITS (FRACTION_BITS),
        .WAVE_BYTES    (WAVE_BYTES)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_st               (st),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_operation        (i_operation),
        .i_register_index   (i_register_index),
        .i_memory_address   (i_memory_address),
        .i_data_byte        (i_data_byte),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_left_sample      (o_left_sample),
        .o_right_sample     (o_right_sample),
        .o_start_mask       (o_start_mask),
        .o_stop_mask        (o_stop_mask),
        .o_irq_channel_mask (o_irq_channel_mask),
        .o_irq_bank_mask    (o_irq_bank_mask)
    );

endmodule

// ===== dv/tb_eight_channel_pcm_playback_mixer.sv =====
// ============================================================================
// Eight-channel PCM playback mixer testbench
// Drives register, wave memory and tick beats through the input channel and
// checks every output beat, field by field, against an in-bench model of the
// mixer. Covers directed corner cases, config phases, random voice setups,
// back-pressure and drain pauses.
// ============================================================================
module tb_eight_channel_pcm_playback_mixer;
    import pcm_mix_pkg::*;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic [7:0]         start;
        logic [7:0]         stop;
        logic [7:0]         irq_ch;
        logic [15:0]        irq_bank;
    } mix_out_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_operation = OP_TICK;
    logic [3:0]  i_register_index = REG_ENV;
    logic [15:0] i_memory_address = '0;
    logic [7:0]  i_data_byte = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic signed [15:0] o_left_sample;
    logic signed [15:0] o_right_sample;
    logic [7:0]  o_start_mask;
    logic [7:0]  o_stop_mask;
    logic [7:0]  o_irq_channel_mask;
    logic [15:0] o_irq_bank_mask;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_MASTER_VOLUME;
    logic [14:0] i_cfg_data = '0;

    eight_channel_pcm_playback_mixer uut (.*);

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // mixer model state
    logic [7:0]  wave_mem [65536];
    logic [7:0]  env_r [8];
    logic [7:0]  pan_r [8];
    logic [7:0]  page_r [8];
    logic [15:0] step_r [8];
    logic [15:0] loop_r [8];
    logic [26:0] addr_r [8];
    logic [2:0]  sel_voice;
    logic [3:0]  wr_bank;
    logic        playing;
    logic [7:0]  off_mask;
    logic [14:0] master_vol;
    logic [7:0]  mute_mask;

    mix_out_t mix_results_q[$];
    int       errors = 0;
    int       burst_left = 0;
    bit       no_gaps = 1'b0;
    int       rx_hold = 0;

    function automatic longint bank_of(longint a);
        return (a >> 23) & 15;
    endfunction

    function automatic longint mix_pair(longint a, longint b);
        longint c;
        c = a + b;
        if (c < -32768 || c > 32767) return c / 2;
        return c;
    endfunction

    function automatic void model_reset();
        foreach (wave_mem[i]) wave_mem[i] = STOP_BYTE;
        for (int c = 0; c < 8; c++) begin
            env_r[c] = 8'hFF; pan_r[c] = '0; page_r[c] = '0;
            step_r[c] = '0; loop_r[c] = '0; addr_r[c] = '0;
        end
        sel_voice = '0; wr_bank = '0; playing = 1'b0; off_mask = 8'hFF;
        master_vol = MASTER_RESET; mute_mask = '0;
    endfunction

    function automatic void reload(logic [7:0] m);
        for (int c = 0; c < 8; c++)
            if (m[c]) addr_r[c] = {page_r[c], 8'h00, 11'd0};
    endfunction

    // expected result of one accepted beat; updates the model state
    function automatic mix_out_t predict_mix(logic [1:0] op, logic [3:0] rg,
                                             logic [15:0] ma, logic [7:0] db);
        mix_out_t r;
        longint lo, ro, addr, ra, ls, l, rr, lv, rv, pb, nb, e, s;
        logic [7:0] d;
        bit at_stop;
        lo = 0; ro = 0;
        r.start = '0; r.stop = '0; r.irq_ch = '0; r.irq_bank = '0;
        if (op == OP_REG) begin
            case (rg)
                REG_ENV:     env_r[sel_voice] = db;
                REG_PAN:     pan_r[sel_voice] = db;
                REG_STEP_LO: step_r[sel_voice][7:0] = db;
                REG_STEP_HI: step_r[sel_voice][15:8] = db;
                REG_LOOP_LO: loop_r[sel_voice][7:0] = db;
                REG_LOOP_HI: loop_r[sel_voice][15:8] = db;
                REG_START: begin
                    page_r[sel_voice] = db;
                    reload(8'd1 << sel_voice);
                end
                REG_CTRL: begin
                    if (db[6]) sel_voice = db[2:0];
                    else wr_bank = db[3:0];
                    if (db[7]) begin
                        if (!playing) r.start = ~off_mask;
                        playing = 1'b1;
                    end else begin
                        r.stop = ~off_mask;
                        playing = 1'b0;
                    end
                end
                REG_ONOFF: begin
                    if (playing) begin
                        r.start = off_mask & ~db;
                        r.stop = ~off_mask & db;
                    end
                    off_mask = db;
                end
                default: ;
            endcase
            reload(r.start | r.stop);
        end else if (op == OP_MEM) begin
            wave_mem[ma] = db;
        end else if (op == OP_TICK) begin
            for (int c = 7; c >= 0; c--) begin
                if (off_mask[c] || step_r[c] == 0) continue;
                ls = loop_r[c];
                addr = addr_r[c];
                ra = addr >> 11;
                d = wave_mem[ra & 16'hFFFF];
                if (d == STOP_BYTE) begin
                    if ((ra & 12'hFFF) == 12'hFFF) begin
                        r.irq_ch[c] = 1'b1;
                        r.irq_bank[bank_of(addr)] = 1'b1;
                    end
                    addr = ls << 11;
                    ra = ls;
                    d = wave_mem[ra & 16'hFFFF];
                end
                at_stop = (d == STOP_BYTE);
                if (!at_stop) begin
                    lv = (pan_r[c] & 15) * env_r[c];
                    rv = (pan_r[c] >> 4) * env_r[c];
                    l = ((d & 8'h7F) * lv) >> 4;
                    rr = ((d & 8'h7F) * rv) >> 4;
                    if (d[7]) begin l = -l; rr = -rr; end
                    if (!mute_mask[c]) begin
                        l = (l * longint'(master_vol)) / 8192;
                        rr = (rr * longint'(master_vol)) / 8192;
                        lo = mix_pair(lo, l);
                        ro = mix_pair(ro, rr);
                    end
                    pb = bank_of(addr);
                    addr += step_r[c];
                    nb = bank_of(addr);
                    if (pb != nb) begin
                        r.irq_ch[c] = 1'b1;
                        r.irq_bank[pb] = 1'b1;
                        if (nb == 0) addr = 0;
                    end
                    e = (addr + step_r[c]) >> 11;
                    for (s = addr >> 11; s < 65536 && s < e; s++) begin
                        if (wave_mem[s] == STOP_BYTE) begin
                            ra = s;
                            at_stop = 1'b1;
                            break;
                        end
                    end
                end
                if (at_stop) begin
                    if ((ra & 12'hFFF) == 12'hFFF) begin
                        r.irq_ch[c] = 1'b1;
                        r.irq_bank[bank_of(addr)] = 1'b1;
                    end
                    addr = ls << 11;
                end
                addr_r[c] = addr[26:0];
            end
            if (lo < -32767) lo = -32767;
            if (lo > 32767) lo = 32767;
            if (ro < -32767) ro = -32767;
            if (ro > 32767) ro = 32767;
        end
        r.left = lo[15:0];
        r.right = ro[15:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    // one input beat, with bursts and random gaps on the sender side
    task automatic send_item(logic [1:0] op, logic [3:0] rg,
                             logic [15:0] ma, logic [7:0] db);
        mix_out_t exp_beat;
        @(negedge i_clk);
        i_valid = 1'b1;
        i_operation = op;
        i_register_index = rg;
        i_memory_address = ma;
        i_data_byte = db;
        do @(posedge i_clk); while (!o_ready);
        exp_beat = predict_mix(op, rg, ma, db);
        mix_results_q.insert(mix_results_q.size(), exp_beat);
        burst_left--;
        if (burst_left <= 0 && !no_gaps) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
    endtask

    task automatic reg_wr(logic [3:0] rg, logic [7:0] db);
        send_item(OP_REG, rg, 16'd0, db);
    endtask

    task automatic tick();
        send_item(OP_TICK, REG_ENV, 16'd0, 8'd0);
    endtask

    // stop offering and wait until every expected beat has come back
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid = 1'b0;
        wait (mix_results_q.size() == 0);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [14:0] val);
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_MASTER_VOLUME) master_vol = val;
        else if (idx == CFG_MUTE_MASK) mute_mask = val[7:0];
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // receiver: long hold-offs on request, else alternating stall patterns
    int rx_cycle = 0;
    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_hold > 0) begin
            i_ready <= 1'b0;
            rx_hold--;
        end else if ((rx_cycle / 80) % 2 == 0) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // result checker
    always @(posedge i_clk) begin : check_results
        mix_out_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (mix_results_q.size() == 0) begin
                report_mismatch("unexpected beat", o_left_sample, 0);
            end else begin
                want = mix_results_q.pop_front();
                if (o_left_sample !== want.left)
                    report_mismatch("left", o_left_sample, want.left);
                if (o_right_sample !== want.right)
                    report_mismatch("right", o_right_sample, want.right);
                if (o_start_mask !== want.start)
                    report_mismatch("start_mask", o_start_mask, want.start);
                if (o_stop_mask !== want.stop)
                    report_mismatch("stop_mask", o_stop_mask, want.stop);
                if (o_irq_channel_mask !== want.irq_ch)
                    report_mismatch("irq_channel", o_irq_channel_mask, want.irq_ch);
                if (o_irq_bank_mask !== want.irq_bank)
                    report_mismatch("irq_bank", o_irq_bank_mask, want.irq_bank);
            end
        end
    end

    // corner cases: reset tick, sign, stop-byte loop, bank end, top wrap
    task automatic test_directed();
        tick();
        send_item(OP_MEM, REG_ENV, 16'h0000, 8'h7F);
        send_item(OP_MEM, REG_ENV, 16'hFFFF, 8'h80);
        send_item(OP_MEM, REG_ENV, 16'h0FFE, 8'h85);
        reg_wr(REG_CTRL, 8'h40);
        reg_wr(REG_ENV, 8'hFF);
        reg_wr(REG_PAN, 8'hFF);
        reg_wr(REG_STEP_LO, 8'h00);
        reg_wr(REG_STEP_HI, 8'h08);
        reg_wr(REG_LOOP_LO, 8'hFE);
        reg_wr(REG_LOOP_HI, 8'h0F);
        reg_wr(REG_START, 8'h0F);
        reg_wr(REG_ONOFF, 8'hFE);
        reg_wr(REG_CTRL, 8'hC0);
        repeat (4) tick();
        // voice 7 near the top of memory with the largest step
        reg_wr(REG_CTRL, 8'hC7);
        reg_wr(REG_STEP_LO, 8'hFF);
        reg_wr(REG_STEP_HI, 8'hFF);
        reg_wr(REG_PAN, 8'h0F);
        reg_wr(REG_START, 8'hFF);
        reg_wr(REG_ONOFF, 8'h7E);
        repeat (3) tick();
        reg_wr(REG_RSVD, 8'hAA);
        send_item(OP_RSVD, REG_RSVD, 16'hFFFF, 8'hFF);
        reg_wr(REG_CTRL, 8'h0F);
        reg_wr(REG_ONOFF, 8'h00);
    endtask

    // fresh voice: select, fill a short wave, program and start it
    task automatic setup_voice();
        logic [2:0]  v;
        logic [7:0]  pg;
        logic [15:0] stp;
        v = 3'($urandom_range(0, 7));
        pg = 8'($urandom_range(0, 255));
        stp = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 65535)) :
                                            16'($urandom_range(1, 4096));
        reg_wr(REG_CTRL, {2'b01, 3'b000, v});
        reg_wr(REG_ENV, 8'($urandom_range(0, 255)));
        reg_wr(REG_PAN, 8'($urandom_range(0, 255)));
        reg_wr(REG_STEP_LO, stp[7:0]);
        reg_wr(REG_STEP_HI, stp[15:8]);
        reg_wr(REG_LOOP_LO, 8'($urandom_range(0, 15)));
        reg_wr(REG_LOOP_HI, pg);
        for (int i = 0; i < 12; i++)
            send_item(OP_MEM, REG_ENV, 16'({pg, 8'h00} + i),
                      8'($urandom_range(0, 254)));
        reg_wr(REG_START, pg);
        reg_wr(REG_ONOFF, 8'($urandom_range(0, 255)) & ~(8'd1 << v));
        reg_wr(REG_CTRL, {2'b11, 3'b000, v});
    endtask

    // mostly ticks, with register and memory noise and periodic voice setups
    task automatic test_random(int n);
        int pick;
        logic [15:0] a;
        logic [7:0]  d;
        for (int i = 0; i < n; i++) begin
            if (i % 60 == 0) setup_voice();
            pick = $urandom_range(0, 99);
            d = ($urandom_range(0, 15) == 0) ? STOP_BYTE : 8'($urandom_range(0, 255));
            if (pick < 6) begin
                reg_wr(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
            end else if (pick < 22) begin
                a = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535)) :
                    16'({page_r[sel_voice], 8'h00} + $urandom_range(0, 1023));
                send_item(OP_MEM, 4'($urandom_range(0, 15)), a, d);
            end else if (pick < 23) begin
                send_item(OP_RSVD, 4'($urandom_range(0, 15)),
                          16'($urandom_range(0, 65535)), d);
            end else begin
                send_item(OP_TICK, 4'($urandom_range(0, 15)),
                          16'($urandom_range(0, 65535)), d);
            end
        end
    endtask

    // config phases at the extremes and in between
    task automatic test_config();
        cfg_write(CFG_MASTER_VOLUME, 15'd0);
        cfg_write(CFG_MUTE_MASK, 15'd0);
        test_random(20);
        cfg_write(CFG_MASTER_VOLUME, 15'd16384);
        cfg_write(CFG_MUTE_MASK, 15'h00FF);
        test_random(20);
        cfg_write(CFG_MASTER_VOLUME, 15'h7FFF);
        cfg_write(CFG_MUTE_MASK, 15'h0055);
        test_random(30);
        cfg_write(CFG_MASTER_VOLUME, 15'($urandom_range(0, 16384)));
        cfg_write(CFG_MUTE_MASK, 15'h00AA);
        test_random(30);
        cfg_write(CFG_MASTER_VOLUME, MASTER_RESET);
        cfg_write(CFG_MUTE_MASK, 15'd0);
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_backpressure();
        wait_idle();
        rx_hold = 400;
        no_gaps = 1'b1;
        test_random(40);
        no_gaps = 1'b0;
    endtask

    // sender pauses until everything outstanding has come back
    task automatic test_drain_pause();
        test_random(30);
        wait_idle();
        test_random(30);
    endtask

    initial begin
        model_reset();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_config();
        test_random(180);
        test_backpressure();
        test_drain_pause();
        wait_idle();
        repeat (1000) @(posedge i_clk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #6000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/pcm_mix_pkg.sv
src/pcm_mix_ctrl.sv
src/pcm_mix_dp.sv
src/eight_channel_pcm_playback_mixer.sv
dv/tb_eight_channel_pcm_playback_mixer.sv
